// ----- rtl/fhi_pkg.sv -----
// Shared types, constants and code tables for the fixed-Huffman inflate block.
// No dependencies.
package fhi_pkg;

  localparam int WINDOW_DEPTH = 32768;
  localparam int WinAw = $clog2(WINDOW_DEPTH);

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_DONE  = 3'd1;
  localparam logic [2:0] ST_TYPE  = 3'd2;
  localparam logic [2:0] ST_CODE  = 3'd3;
  localparam logic [2:0] ST_DIST  = 3'd4;
  localparam logic [2:0] ST_TRUNC = 3'd5;

  typedef enum logic [2:0] {
    PH_FINAL, PH_TYPE, PH_LIT, PH_LEXTRA, PH_DIST, PH_DEXTRA, PH_HALT
  } dphase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_BIT, S_COPY_RD, S_COPY_WR, S_FINISH, S_PACK_RD, S_PACK_CAP, S_OUT
  } cstate_t;

  typedef struct packed {
    logic load;
    logic bit_step;
    logic copy_rd;
    logic copy_wr;
    logic finish;
    logic pack_rd;
    logic pack_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic halted;
    logic bits_done;
    logic copy_go;
    logic copy_last;
    logic pack_more;
    logic out_last;
  } stat_t;

  function automatic logic [8:0] len_base(input logic [4:0] i);
    case (i)
      5'd0: return 9'd3;    5'd1: return 9'd4;    5'd2: return 9'd5;    5'd3: return 9'd6;
      5'd4: return 9'd7;    5'd5: return 9'd8;    5'd6: return 9'd9;    5'd7: return 9'd10;
      5'd8: return 9'd11;   5'd9: return 9'd13;   5'd10: return 9'd15;  5'd11: return 9'd17;
      5'd12: return 9'd19;  5'd13: return 9'd23;  5'd14: return 9'd27;  5'd15: return 9'd31;
      5'd16: return 9'd35;  5'd17: return 9'd43;  5'd18: return 9'd51;  5'd19: return 9'd59;
      5'd20: return 9'd67;  5'd21: return 9'd83;  5'd22: return 9'd99;  5'd23: return 9'd115;
      5'd24: return 9'd131; 5'd25: return 9'd163; 5'd26: return 9'd195; 5'd27: return 9'd227;
      default: return 9'd258;
    endcase
  endfunction

  function automatic logic [3:0] len_extra(input logic [4:0] i);
    if (i < 5'd8 || i == 5'd28) return 4'd0;
    return 4'((i - 5'd4) >> 2);
  endfunction

  function automatic logic [14:0] dist_base(input logic [4:0] i);
    case (i)
      5'd0: return 15'd1;      5'd1: return 15'd2;      5'd2: return 15'd3;
      5'd3: return 15'd4;      5'd4: return 15'd5;      5'd5: return 15'd7;
      5'd6: return 15'd9;      5'd7: return 15'd13;     5'd8: return 15'd17;
      5'd9: return 15'd25;     5'd10: return 15'd33;    5'd11: return 15'd49;
      5'd12: return 15'd65;    5'd13: return 15'd97;    5'd14: return 15'd129;
      5'd15: return 15'd193;   5'd16: return 15'd257;   5'd17: return 15'd385;
      5'd18: return 15'd513;   5'd19: return 15'd769;   5'd20: return 15'd1025;
      5'd21: return 15'd1537;  5'd22: return 15'd2049;  5'd23: return 15'd3073;
      5'd24: return 15'd4097;  5'd25: return 15'd6145;  5'd26: return 15'd8193;
      5'd27: return 15'd12289; 5'd28: return 15'd16385; default: return 15'd24577;
    endcase
  endfunction

  function automatic logic [3:0] dist_extra(input logic [4:0] i);
    if (i < 5'd4) return 4'd0;
    return 4'((i - 5'd2) >> 1);
  endfunction

endpackage

// ----- rtl/fhi_ctrl.sv -----
// Sequencer for the fixed-Huffman inflate block.
// Depends on fhi_pkg.
module fhi_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            out_fire,
  input  fhi_pkg::stat_t  st,
  output fhi_pkg::cmd_t   cmd,
  output logic            in_ready,
  output logic            out_valid
);

  fhi_pkg::cstate_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fhi_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fhi_pkg::S_IDLE: if (in_fire) state_next = fhi_pkg::S_BIT;
      fhi_pkg::S_BIT: begin
        if (st.halted || st.bits_done) state_next = fhi_pkg::S_FINISH;
        else if (st.copy_go) state_next = fhi_pkg::S_COPY_RD;
      end
      fhi_pkg::S_COPY_RD: state_next = fhi_pkg::S_COPY_WR;
      fhi_pkg::S_COPY_WR: state_next = st.copy_last ? fhi_pkg::S_BIT : fhi_pkg::S_COPY_RD;
      fhi_pkg::S_FINISH: state_next = fhi_pkg::S_PACK_RD;
      fhi_pkg::S_PACK_RD: state_next = st.pack_more ? fhi_pkg::S_PACK_CAP : fhi_pkg::S_OUT;
      fhi_pkg::S_PACK_CAP: state_next = fhi_pkg::S_PACK_RD;
      fhi_pkg::S_OUT: begin
        if (out_fire) state_next = st.out_last ? fhi_pkg::S_IDLE : fhi_pkg::S_PACK_RD;
      end
      default: state_next = fhi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      fhi_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      fhi_pkg::S_BIT: cmd.bit_step = !(st.halted || st.bits_done);
      fhi_pkg::S_COPY_RD: cmd.copy_rd = 1'b1;
      fhi_pkg::S_COPY_WR: cmd.copy_wr = 1'b1;
      fhi_pkg::S_FINISH: cmd.finish = 1'b1;
      fhi_pkg::S_PACK_RD: begin
        cmd.pack_rd = st.pack_more;
        cmd.out_load = !st.pack_more;
      end
      fhi_pkg::S_PACK_CAP: cmd.pack_cap = 1'b1;
      fhi_pkg::S_OUT: out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/fhi_datapath.sv -----
// Bit decoder, history window and result packer for the inflate block.
// Depends on fhi_pkg.
module fhi_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  fhi_pkg::cmd_t         cmd,
  input  logic [7:0]            in_byte,
  input  logic                  stream_end,
  output fhi_pkg::stat_t        st,
  output logic [63:0]           out_bytes,
  output logic [3:0]            out_count,
  output logic                  run_last,
  output logic [2:0]            status
);

  localparam int Aw = fhi_pkg::WinAw;

  logic [7:0]  byte_reg;
  logic        end_reg;
  logic [3:0]  bit_cnt;
  fhi_pkg::dphase_t phase, phase_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [8:0]  acc, acc_next;
  logic        last_flag, last_flag_next;
  logic [3:0]  extra_needed, extra_needed_next;
  logic [14:0] base_value, base_value_next;
  logic [12:0] extra_value, extra_value_next;
  logic [8:0]  match_length, match_length_next;
  logic [15:0] match_dist, match_dist_next;
  logic [8:0]  copy_left;
  logic [Aw-1:0] wptr, start_ptr, rd_ptr;
  logic [Aw:0]   bytes_written;
  logic [2:0]  sticky, sticky_next;
  logic [8:0]  outlen, rem;
  logic [63:0] pack;
  logic [3:0]  pack_cnt;
  logic        lit_emit, copy_go;
  logic [7:0]  lit_byte;
  logic [7:0]  hist [fhi_pkg::WINDOW_DEPTH];
  logic [7:0]  rdata;
  logic [Aw-1:0] rd_addr;
  logic        we;
  logic [7:0]  wdata;
  logic        b;
  logic [9:0]  sym;
  logic        hit;
  logic [8:0]  acc_n;
  logic [3:0]  bc_n;
  logic [12:0] ev_n;
  logic [15:0] dcand;

  assign b = byte_reg[bit_cnt[2:0]];

  always_comb begin
    phase_next = phase;
    bit_counter_next = bit_counter;
    acc_next = acc;
    last_flag_next = last_flag;
    extra_needed_next = extra_needed;
    base_value_next = base_value;
    extra_value_next = extra_value;
    match_length_next = match_length;
    match_dist_next = match_dist;
    sticky_next = sticky;
    lit_emit = 1'b0;
    lit_byte = '0;
    copy_go = 1'b0;
    hit = 1'b0;
    sym = '0;
    acc_n = '0;
    bc_n = bit_counter + 4'd1;
    ev_n = extra_value | (13'(b) << bit_counter);
    dcand = '0;
    unique case (phase)
      fhi_pkg::PH_FINAL: begin
        last_flag_next = b;
        bit_counter_next = '0;
        acc_next = '0;
        phase_next = fhi_pkg::PH_TYPE;
      end
      fhi_pkg::PH_TYPE: begin
        acc_n = acc | (9'(b) << bit_counter[0]);
        bit_counter_next = bc_n;
        acc_next = acc_n;
        if (bc_n >= 4'd2) begin
          bit_counter_next = '0;
          acc_next = '0;
          if (acc_n[1:0] == 2'd1) begin
            phase_next = fhi_pkg::PH_LIT;
          end else begin
            sticky_next = fhi_pkg::ST_TYPE;
            phase_next = fhi_pkg::PH_HALT;
          end
        end
      end
      fhi_pkg::PH_LIT: begin
        acc_n = {acc[7:0], b};
        bit_counter_next = bc_n;
        acc_next = acc_n;
        if (bc_n == 4'd7 && acc_n <= 9'h017) begin
          hit = 1'b1; sym = 10'(acc_n) + 10'h100;
        end else if (bc_n == 4'd8 && acc_n >= 9'h030 && acc_n <= 9'h0BF) begin
          hit = 1'b1; sym = 10'(acc_n) - 10'h030;
        end else if (bc_n == 4'd8 && acc_n >= 9'h0C0 && acc_n <= 9'h0C7) begin
          hit = 1'b1; sym = 10'(acc_n) - 10'h0C0 + 10'h118;
        end else if (bc_n >= 4'd9) begin
          if (acc_n >= 9'h190) begin
            hit = 1'b1; sym = 10'(acc_n) - 10'h190 + 10'h090;
          end else begin
            sticky_next = fhi_pkg::ST_CODE;
            phase_next = fhi_pkg::PH_HALT;
          end
        end
        if (hit) begin
          bit_counter_next = '0;
          acc_next = '0;
          if (sym < 10'd256) begin
            lit_emit = 1'b1;
            lit_byte = sym[7:0];
          end else if (sym == 10'd256) begin
            if (last_flag) begin
              sticky_next = fhi_pkg::ST_DONE;
              phase_next = fhi_pkg::PH_HALT;
            end else begin
              phase_next = fhi_pkg::PH_FINAL;
            end
          end else if (sym <= 10'd285) begin
            base_value_next = 15'(fhi_pkg::len_base(5'(sym - 10'd257)));
            extra_needed_next = fhi_pkg::len_extra(5'(sym - 10'd257));
            extra_value_next = '0;
            if (fhi_pkg::len_extra(5'(sym - 10'd257)) == 4'd0) begin
              match_length_next = fhi_pkg::len_base(5'(sym - 10'd257));
              phase_next = fhi_pkg::PH_DIST;
            end else begin
              phase_next = fhi_pkg::PH_LEXTRA;
            end
          end else begin
            sticky_next = fhi_pkg::ST_CODE;
            phase_next = fhi_pkg::PH_HALT;
          end
        end
      end
      fhi_pkg::PH_LEXTRA: begin
        extra_value_next = ev_n;
        bit_counter_next = bc_n;
        if (bc_n >= extra_needed) begin
          bit_counter_next = '0;
          match_length_next = 9'(base_value + 15'(ev_n));
          phase_next = fhi_pkg::PH_DIST;
        end
      end
      fhi_pkg::PH_DIST: begin
        acc_n = {4'd0, acc[3:0], b};
        bit_counter_next = bc_n;
        acc_next = acc_n;
        if (bc_n >= 4'd5) begin
          bit_counter_next = '0;
          acc_next = '0;
          if (acc_n[4:0] >= 5'd30) begin
            sticky_next = fhi_pkg::ST_CODE;
            phase_next = fhi_pkg::PH_HALT;
          end else begin
            base_value_next = fhi_pkg::dist_base(acc_n[4:0]);
            extra_needed_next = fhi_pkg::dist_extra(acc_n[4:0]);
            extra_value_next = '0;
            if (fhi_pkg::dist_extra(acc_n[4:0]) == 4'd0) begin
              dcand = 16'(fhi_pkg::dist_base(acc_n[4:0]));
              copy_go = 1'b1;
            end else begin
              phase_next = fhi_pkg::PH_DEXTRA;
            end
          end
        end
      end
      fhi_pkg::PH_DEXTRA: begin
        extra_value_next = ev_n;
        bit_counter_next = bc_n;
        if (bc_n >= extra_needed) begin
          bit_counter_next = '0;
          dcand = 16'(base_value) + 16'(ev_n);
          copy_go = 1'b1;
        end
      end
      default: phase_next = phase;
    endcase
    if (copy_go) begin
      if (dcand == 16'd0 || 17'(dcand) > 17'(bytes_written)) begin
        copy_go = 1'b0;
        sticky_next = fhi_pkg::ST_DIST;
        phase_next = fhi_pkg::PH_HALT;
      end else begin
        match_dist_next = dcand;
        phase_next = fhi_pkg::PH_LIT;
      end
    end
  end

  assign we = (cmd.bit_step && lit_emit) || cmd.copy_wr;
  assign wdata = cmd.copy_wr ? rdata : lit_byte;
  assign rd_addr = cmd.copy_rd ? wptr - match_dist[Aw-1:0] : rd_ptr;

  always_ff @(posedge clk) begin
    if (we) begin
      hist[wptr] <= wdata;
    end
    rdata <= hist[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fhi_pkg::PH_FINAL;
      bit_counter <= '0;
      acc <= '0;
      last_flag <= 1'b0;
      extra_needed <= '0;
      base_value <= '0;
      extra_value <= '0;
      match_length <= '0;
      match_dist <= '0;
      wptr <= '0;
      bytes_written <= '0;
      sticky <= fhi_pkg::ST_RUN;
      bit_cnt <= '0;
      copy_left <= '0;
      outlen <= '0;
      rem <= '0;
      pack_cnt <= '0;
      run_last <= 1'b0;
    end else begin
      if (cmd.load) begin
        bit_cnt <= '0;
        outlen <= '0;
        start_ptr <= wptr;
      end
      if (cmd.bit_step) begin
        phase <= phase_next;
        bit_counter <= bit_counter_next;
        acc <= acc_next;
        last_flag <= last_flag_next;
        extra_needed <= extra_needed_next;
        base_value <= base_value_next;
        extra_value <= extra_value_next;
        match_length <= match_length_next;
        match_dist <= match_dist_next;
        sticky <= sticky_next;
        bit_cnt <= bit_cnt + 4'd1;
        if (copy_go) copy_left <= match_length_next;
      end
      if (cmd.copy_wr) copy_left <= copy_left - 9'd1;
      if (we) begin
        wptr <= wptr + Aw'(1);
        if (bytes_written < (Aw+1)'(fhi_pkg::WINDOW_DEPTH)) begin
          bytes_written <= bytes_written + (Aw+1)'(1);
        end
        outlen <= outlen + 9'd1;
      end
      if (cmd.finish) begin
        if (end_reg && sticky == fhi_pkg::ST_RUN) sticky <= fhi_pkg::ST_TRUNC;
        rem <= outlen;
        rd_ptr <= start_ptr;
        pack <= '0;
        pack_cnt <= '0;
      end
      if (cmd.pack_rd) rd_ptr <= rd_ptr + Aw'(1);
      if (cmd.pack_cap) begin
        pack[pack_cnt[2:0]*8 +: 8] <= rdata;
        pack_cnt <= pack_cnt + 4'd1;
        rem <= rem - 9'd1;
      end
      if (cmd.out_load) begin
        out_bytes <= pack;
        out_count <= pack_cnt;
        run_last <= (rem == 9'd0);
        pack <= '0;
        pack_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_reg <= in_byte;
      end_reg <= stream_end;
    end
  end

  assign status = sticky;
  assign st.halted = (sticky != fhi_pkg::ST_RUN);
  assign st.bits_done = (bit_cnt == 4'd8);
  assign st.copy_go = copy_go;
  assign st.copy_last = (copy_left == 9'd1);
  assign st.pack_more = (pack_cnt != 4'd8) && (rem != 9'd0);
  assign st.out_last = run_last;

  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    (sticky != fhi_pkg::ST_RUN) |=> (sticky == $past(sticky)))
    else $error("sticky status changed after halt");
  a_copy_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_wr |-> (copy_left != 9'd0))
    else $error("copy write with no bytes left");
  a_pack_bound: assert property (@(posedge clk) disable iff (rst)
    pack_cnt <= 4'd8)
    else $error("packer overran eight bytes");
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_written <= (Aw+1)'(fhi_pkg::WINDOW_DEPTH))
    else $error("written count beyond window");

endmodule

// ----- rtl/fixed_huffman_inflate.sv -----
// Fixed-Huffman DEFLATE decoder, one compressed byte in flight at a time; decoded bytes
// leave packed up to eight per transaction. Decoding stops at the bit that halts it; a byte
// taken once halted decodes no bits and still yields one result carrying the status. A new
// byte is taken only after the last result for the previous one, so output stalls hold input.
// Synchronous reset clears all control state; the history window is not cleared.
module fixed_huffman_inflate (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  input  logic        s_tlast,   // stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_bytes[63:0], out_count[67:64], status[70:68], zero
  output logic        m_tlast    // run_last
);

  fhi_pkg::cmd_t  cmd;
  fhi_pkg::stat_t st;
  logic [63:0] out_bytes;
  logic [3:0]  out_count;
  logic [2:0]  status;
  logic        run_last;

  fhi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (s_tvalid && s_tready),
    .out_fire  (m_tvalid && m_tready),
    .st        (st),
    .cmd       (cmd),
    .in_ready  (s_tready),
    .out_valid (m_tvalid)
  );

  fhi_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_byte    (s_tdata),
    .stream_end (s_tlast),
    .st         (st),
    .out_bytes  (out_bytes),
    .out_count  (out_count),
    .run_last   (run_last),
    .status     (status)
  );

  assign m_tdata = {1'b0, status, out_count, out_bytes};
  assign m_tlast = run_last;

endmodule

// ----- dv/fixed_huffman_inflate_tb.sv -----
// Self-checking testbench for fixed_huffman_inflate: drives a fixed-Huffman DEFLATE
// stream byte by byte, predicts decoded output and status, and scoreboards results.
// Depends on rtl/fhi_pkg.sv and rtl/fixed_huffman_inflate.sv.
module fixed_huffman_inflate_tb;

  localparam int LAT_CYC = 1500;
  localparam int CALM_ITEMS = 40;

  localparam int LBASE [29] = '{3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19, 23, 27, 31,
                                35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258};
  localparam int LEXT [29] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
                               3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 0};
  localparam int DBASE [30] = '{1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97, 129, 193,
                                257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145,
                                8193, 12289, 16385, 24577};
  localparam int DEXT [30] = '{0, 0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6, 6,
                               7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 13, 13};

  localparam int SYM_EOB = 256;

  typedef struct {
    logic [7:0] byte_val;
    logic       end_flag;
  } cbyte_t;

  typedef struct {
    logic [71:0] data;
    logic        last;
  } dec_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;

  fixed_huffman_inflate dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  cbyte_t    byte_q[$];
  dec_word_t word_q[$];
  bit        gen_bits[$];
  int        n_items;
  int        n_sent = 0;
  int        errors = 0;
  bit        calm = 1'b0;
  int        drv_idle = 0;
  int        mon_idle = 0;

  fhi_pkg::dphase_t ph;
  int          bcnt, acc, xneed, xbase, xval, mlen, wptr, nwr;
  logic        lastf;
  logic [2:0]  sts;
  logic [7:0]  hist [fhi_pkg::WINDOW_DEPTH];
  logic [7:0]  dec_bytes[$];

  initial forever #6 clk = ~clk;

  // decoder model
  task automatic halt_at(input logic [2:0] code);
    sts = code;
    ph = fhi_pkg::PH_HALT;
  endtask

  task automatic put_out(input logic [7:0] b);
    hist[wptr] = b;
    wptr = (wptr + 1 >= fhi_pkg::WINDOW_DEPTH) ? 0 : wptr + 1;
    if (nwr < fhi_pkg::WINDOW_DEPTH) nwr++;
    dec_bytes.push_back(b);
  endtask

  task automatic copy_back(input int back_dist);
    int src;
    if (back_dist == 0 || back_dist > nwr) begin
      halt_at(fhi_pkg::ST_DIST);
      return;
    end
    for (int k = 0; k < mlen; k++) begin
      src = (wptr >= back_dist) ? wptr - back_dist
                                : wptr + fhi_pkg::WINDOW_DEPTH - back_dist;
      put_out(hist[src]);
    end
    ph = fhi_pkg::PH_LIT;
  endtask

  task automatic lit_len(input int sym);
    if (sym < 256) begin
      put_out(sym[7:0]);
    end else if (sym == SYM_EOB) begin
      if (lastf) halt_at(fhi_pkg::ST_DONE);
      else ph = fhi_pkg::PH_FINAL;
    end else if (sym <= 285) begin
      xbase = LBASE[sym - 257];
      xneed = LEXT[sym - 257];
      xval = 0;
      if (xneed == 0) begin
        mlen = xbase;
        ph = fhi_pkg::PH_DIST;
      end else begin
        ph = fhi_pkg::PH_LEXTRA;
      end
    end else begin
      halt_at(fhi_pkg::ST_CODE);
    end
  endtask

  task automatic decode_bit(input int b);
    int sym;
    bit hit;
    hit = 0;
    sym = 0;
    case (ph)
      fhi_pkg::PH_FINAL: begin
        lastf = b[0];
        bcnt = 0;
        acc = 0;
        ph = fhi_pkg::PH_TYPE;
      end
      fhi_pkg::PH_TYPE: begin
        acc |= b << (bcnt & 1);
        bcnt++;
        if (bcnt >= 2) begin
          bcnt = 0;
          if ((acc & 3) == 1) ph = fhi_pkg::PH_LIT;
          else halt_at(fhi_pkg::ST_TYPE);
          acc = 0;
        end
      end
      fhi_pkg::PH_LIT: begin
        acc = ((acc << 1) | b) & 'h1FF;
        bcnt++;
        if (bcnt == 7 && acc <= 'h17) begin
          hit = 1; sym = acc + 'h100;
        end else if (bcnt == 8 && acc >= 'h30 && acc <= 'hBF) begin
          hit = 1; sym = acc - 'h30;
        end else if (bcnt == 8 && acc >= 'hC0 && acc <= 'hC7) begin
          hit = 1; sym = acc - 'hC0 + 'h118;
        end else if (bcnt >= 9) begin
          if (acc >= 'h190) begin
            hit = 1; sym = acc - 'h190 + 'h90;
          end else begin
            halt_at(fhi_pkg::ST_CODE);
            return;
          end
        end
        if (hit) begin
          bcnt = 0;
          acc = 0;
          lit_len(sym);
        end
      end
      fhi_pkg::PH_LEXTRA: begin
        xval |= b << (bcnt & 15);
        bcnt++;
        if (bcnt >= xneed) begin
          bcnt = 0;
          mlen = (xbase + xval) & 'h1FF;
          ph = fhi_pkg::PH_DIST;
        end
      end
      fhi_pkg::PH_DIST: begin
        acc = ((acc << 1) | b) & 'h1F;
        bcnt++;
        if (bcnt >= 5) begin
          sym = acc;
          bcnt = 0;
          acc = 0;
          if (sym >= 30) begin
            halt_at(fhi_pkg::ST_CODE);
            return;
          end
          xbase = DBASE[sym];
          xneed = DEXT[sym];
          xval = 0;
          if (xneed == 0) copy_back(xbase);
          else ph = fhi_pkg::PH_DEXTRA;
        end
      end
      fhi_pkg::PH_DEXTRA: begin
        xval |= b << (bcnt & 15);
        bcnt++;
        if (bcnt >= xneed) begin
          bcnt = 0;
          copy_back((xbase + xval) & 'hFFFF);
        end
      end
      default: ;
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic e);
    int nres;
    int cnt;
    dec_word_t w;
    logic [63:0] packed_bytes;
    dec_bytes.delete();
    if (sts == fhi_pkg::ST_RUN) begin
      for (int j = 0; j < 8 && ph != fhi_pkg::PH_HALT; j++) decode_bit(b[j]);
      if (e && sts == fhi_pkg::ST_RUN) halt_at(fhi_pkg::ST_TRUNC);
    end
    nres = (dec_bytes.size() + 7) / 8;
    if (nres == 0) nres = 1;
    for (int k = 0; k < nres; k++) begin
      packed_bytes = '0;
      cnt = 0;
      while (cnt < 8 && k * 8 + cnt < dec_bytes.size()) begin
        packed_bytes[8*cnt +: 8] = dec_bytes[k * 8 + cnt];
        cnt++;
      end
      w.data = {1'b0, sts, cnt[3:0], packed_bytes};
      w.last = (k + 1 == nres);
      word_q.push_back(w);
    end
  endtask

  // stream encoder
  task automatic put_msb(input int v, input int n);
    for (int i = n - 1; i >= 0; i--) gen_bits.push_back(v[i]);
  endtask

  task automatic put_lsb(input int v, input int n);
    for (int i = 0; i < n; i++) gen_bits.push_back(v[i]);
  endtask

  task automatic put_sym(input int s);
    if (s < 144) put_msb(s + 'h30, 8);
    else if (s < 256) put_msb(s - 144 + 'h190, 9);
    else if (s < 280) put_msb(s - 256, 7);
    else put_msb(s - 280 + 'hC0, 8);
  endtask

  task automatic put_header(input int fin, input int btype);
    put_lsb(fin, 1);
    put_lsb(btype, 2);
  endtask

  task automatic put_match(input int ls, input int lx, input int dc, input int dx,
                           inout int produced);
    put_sym(ls + 257);
    put_lsb(lx, LEXT[ls]);
    put_msb(dc, 5);
    put_lsb(dx, DEXT[dc]);
    produced += LBASE[ls] + lx;
  endtask

  task automatic put_rand_match(inout int produced);
    int ls, lx, dc, dx, avail, mx;
    avail = (produced < fhi_pkg::WINDOW_DEPTH) ? produced : fhi_pkg::WINDOW_DEPTH;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: ls = $urandom_range(0, 7);
      5, 6: ls = 28;
      default: ls = $urandom_range(0, 28);
    endcase
    lx = (LEXT[ls] == 0) ? 0 : $urandom_range(0, (1 << LEXT[ls]) - 1);
    dc = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 9) : $urandom_range(0, 29);
    while (DBASE[dc] > avail) dc--;
    mx = (1 << DEXT[dc]) - 1;
    if (mx > avail - DBASE[dc]) mx = avail - DBASE[dc];
    dx = $urandom_range(0, mx);
    put_match(ls, lx, dc, dx, produced);
  endtask

  task automatic build_stream();
    int produced, ending, avail;
    cbyte_t cb;
    produced = 0;
    put_header(0, 1);
    put_sym(0); put_sym(143); put_sym(144); put_sym(255);
    produced = 4;
    put_match(0, 0, 0, 0, produced);
    put_sym(SYM_EOB);
    put_header(0, 1);
    put_match(28, 0, 3, 0, produced);
    put_match(27, 31, 4, 1, produced);
    put_match(8, 1, 29, 0, produced);
    gen_bits = gen_bits[0 : gen_bits.size() - 19];
    put_msb(0, 5);
    while (gen_bits.size() < 8 * 370) begin
      case ($urandom_range(0, 19))
        0: begin
          put_sym(SYM_EOB);
          put_header(0, 1);
        end
        1, 2, 3, 4, 5, 6, 7, 8: begin
          put_sym($urandom_range(0, 255));
          produced++;
        end
        default: put_rand_match(produced);
      endcase
    end
    avail = (produced < fhi_pkg::WINDOW_DEPTH) ? produced : fhi_pkg::WINDOW_DEPTH;
    ending = $urandom_range(0, 4);
    if (ending == 3 && avail >= fhi_pkg::WINDOW_DEPTH) ending = 2;
    case (ending)
      0: begin
        put_sym(SYM_EOB);
        put_header(1, 1);
        put_sym($urandom_range(0, 255));
        put_sym(SYM_EOB);
      end
      1: begin
        put_sym(SYM_EOB);
        case ($urandom_range(0, 2))
          0: put_header($urandom_range(0, 1), 0);
          1: put_header($urandom_range(0, 1), 2);
          default: put_header($urandom_range(0, 1), 3);
        endcase
      end
      2: begin
        if ($urandom_range(0, 1) == 0) begin
          put_sym($urandom_range(286, 287));
        end else begin
          put_sym(257);
          put_msb($urandom_range(30, 31), 5);
        end
      end
      3: begin
        put_sym(257);
        put_msb(29, 5);
        put_lsb(avail + 1 - 24577 + $urandom_range(0, 20), 13);
      end
      default: put_sym($urandom_range(0, 255));
    endcase
    while (gen_bits.size() % 8 != 0) gen_bits.push_back(1'($urandom_range(0, 1)));
    for (int i = 0; i < gen_bits.size(); i += 8) begin
      for (int j = 0; j < 8; j++) cb.byte_val[j] = gen_bits[i + j];
      cb.end_flag = (i + 8 == gen_bits.size());
      byte_q.push_back(cb);
    end
    repeat (8) begin
      cb.byte_val = 8'($urandom_range(0, 255));
      cb.end_flag = 1'($urandom_range(0, 1));
      byte_q.push_back(cb);
    end
  endtask

  initial begin
    ph = fhi_pkg::PH_FINAL;
    bcnt = 0; acc = 0; xneed = 0; xbase = 0; xval = 0; mlen = 0;
    wptr = 0; nwr = 0; lastf = 1'b0; sts = fhi_pkg::ST_RUN;
    build_stream();
    n_items = byte_q.size();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (byte_q.size() != 0 || s_tvalid || word_q.size() != 0);
    repeat (LAT_CYC) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #(12 * 4000000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        calm = (n_sent >= n_items - CALM_ITEMS);
        if (drv_idle == 0 && !calm && $urandom_range(0, 5) == 0)
          drv_idle = $urandom_range(1, 3);
        if (drv_idle > 0) begin
          drv_idle--;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          s_tdata <= byte_q[0].byte_val;
          s_tlast <= byte_q[0].end_flag;
          void'(byte_q.pop_front());
          n_sent++;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (word_q.size() == 0) begin
          $display("%0t unexpected transaction: actual %h last %b", $time, m_tdata, m_tlast);
          errors++;
        end else begin
          if (m_tdata[63:0] !== word_q[0].data[63:0]) begin
            $display("%0t out_bytes: expected %h actual %h", $time,
                     word_q[0].data[63:0], m_tdata[63:0]);
            errors++;
          end
          if (m_tdata[67:64] !== word_q[0].data[67:64]) begin
            $display("%0t out_count: expected %0d actual %0d", $time,
                     word_q[0].data[67:64], m_tdata[67:64]);
            errors++;
          end
          if (m_tdata[70:68] !== word_q[0].data[70:68]) begin
            $display("%0t status: expected %0d actual %0d", $time,
                     word_q[0].data[70:68], m_tdata[70:68]);
            errors++;
          end
          if (m_tlast !== word_q[0].last) begin
            $display("%0t run_last: expected %b actual %b", $time, word_q[0].last, m_tlast);
            errors++;
          end
          void'(word_q.pop_front());
        end
      end
      if (mon_idle == 0 && !calm && $urandom_range(0, 4) == 0)
        mon_idle = $urandom_range(1, 3);
      if (mon_idle > 0) begin
        mon_idle--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

endmodule

// ----- filelist.f -----
rtl/fhi_pkg.sv
rtl/fhi_ctrl.sv
rtl/fhi_datapath.sv
rtl/fixed_huffman_inflate.sv
dv/fixed_huffman_inflate_tb.sv
